// ===== rtl/s2cg_pkg.sv =====
// Shared types, constants and font table for the seconds-to-clock-glyph block.
`timescale 1ns / 1ps

package s2cg_pkg;

    localparam int IN_W     = 26;
    localparam int POS_W    = 4;
    localparam int SYM_W    = 4;
    localparam int GLYPH_W  = 42;
    localparam int Q1_W     = 21;   // total_seconds / 60
    localparam int HOURS_W  = 15;   // total_seconds / 3600
    localparam int DEF_MAX_HOUR_DIGITS = 4;

    // Reciprocals for exact division by a constant (multiply, then shift).
    localparam logic [26:0] M60_A = 27'd71582789;   // ceil(2^32 / 60)
    localparam int          M60_A_SH = 32;
    localparam logic [21:0] M60_B = 22'd2236963;    // ceil(2^27 / 60)
    localparam int          M60_B_SH = 27;
    localparam logic [15:0] M10   = 16'd52429;      // ceil(2^19 / 10)
    localparam int          M10_SH = 19;

    localparam logic [SYM_W-1:0] SYM_COLON = 4'd10;
    localparam logic [SYM_W-1:0] SYM_NINE  = 4'd9;

    // Row patterns, left pixel is the MSB.
    localparam logic [5:0] R_FULL  = 6'h3F;
    localparam logic [5:0] R_SIDES = 6'h21;
    localparam logic [5:0] R_RIGHT = 6'h01;
    localparam logic [5:0] R_LEFT  = 6'h20;
    localparam logic [5:0] R_BAR   = 6'h1E;
    localparam logic [5:0] R_NONE  = 6'h00;

    typedef struct packed {
        logic load;
        logic div_a;
        logic div_b;
        logic setup;
        logic digit_step;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic sat;
        logic hval_small;
        logic last_pos;
    } t_dp_stat;

    function automatic longint unsigned pow10(input int n);
        longint unsigned v;
        v = 1;
        for (int i = 0; i < n; i++) begin
            v = v * 10;
        end
        return v;
    endfunction

    function automatic logic [GLYPH_W-1:0] glyph_of(input logic [SYM_W-1:0] sym);
        logic [GLYPH_W-1:0] g;
        case (sym)
            4'd0: g = {R_FULL, R_SIDES, R_SIDES, R_SIDES, R_SIDES, R_SIDES, R_FULL};
            4'd1: g = {R_RIGHT, R_RIGHT, R_RIGHT, R_RIGHT, R_RIGHT, R_RIGHT, R_RIGHT};
            4'd2: g = {R_FULL, R_RIGHT, R_RIGHT, R_FULL, R_LEFT, R_LEFT, R_FULL};
            4'd3: g = {R_FULL, R_RIGHT, R_RIGHT, R_FULL, R_RIGHT, R_RIGHT, R_FULL};
            4'd4: g = {R_SIDES, R_SIDES, R_SIDES, R_FULL, R_RIGHT, R_RIGHT, R_RIGHT};
            4'd5: g = {R_FULL, R_LEFT, R_LEFT, R_FULL, R_RIGHT, R_RIGHT, R_FULL};
            4'd6: g = {R_FULL, R_LEFT, R_LEFT, R_FULL, R_SIDES, R_SIDES, R_FULL};
            4'd7: g = {R_FULL, R_RIGHT, R_RIGHT, R_RIGHT, R_RIGHT, R_RIGHT, R_RIGHT};
            4'd8: g = {R_FULL, R_SIDES, R_SIDES, R_FULL, R_SIDES, R_SIDES, R_FULL};
            4'd9: g = {R_FULL, R_SIDES, R_SIDES, R_FULL, R_RIGHT, R_RIGHT, R_FULL};
            default: g = {R_NONE, R_BAR, R_BAR, R_NONE, R_BAR, R_BAR, R_NONE};
        endcase
        return g;
    endfunction

    // Tens digit of a value below 64.
    function automatic logic [3:0] tens_of(input logic [5:0] x);
        logic [9:0] p;
        p = 10'(x) * 10'd13;
        return p[9:7 - 0 + 0] == 3'd0 ? 4'd0 : 4'(p[9:7]);
    endfunction

endpackage

// ===== rtl/s2cg_if.sv =====
// Handshake channels for the time input and the glyph output.
`timescale 1ns / 1ps

interface s2cg_in_if import s2cg_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [IN_W-1:0] total_seconds;

    modport source (output valid, output total_seconds, input ready);
    modport sink   (input valid, input total_seconds, output ready);
endinterface

interface s2cg_out_if import s2cg_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [POS_W-1:0]   char_position;
    logic [SYM_W-1:0]   symbol_code;
    logic [GLYPH_W-1:0] glyph_bits;
    logic               last_char;

    modport source (output valid, output char_position, output symbol_code,
                    output glyph_bits, output last_char, input ready);
    modport sink   (input valid, input char_position, input symbol_code,
                    input glyph_bits, input last_char, output ready);
endinterface

// ===== rtl/s2cg_dp.sv =====
// Datapath: time split, hour digit extraction and glyph output register.
`timescale 1ns / 1ps

module s2cg_dp import s2cg_pkg::*; #(
    parameter int MAX_HOUR_DIGITS = DEF_MAX_HOUR_DIGITS
) (
    input  logic               i_clk,
    input  t_dp_cmd            i_cmd,
    input  logic [IN_W-1:0]    i_total_seconds,
    output t_dp_stat           o_stat,
    output logic [POS_W-1:0]   o_char_position,
    output logic [SYM_W-1:0]   o_symbol_code,
    output logic [GLYPH_W-1:0] o_glyph_bits,
    output logic               o_last_char
);

    localparam int HD_MAX    = ((MAX_HOUR_DIGITS + 1) / 2) * 2;
    localparam int DIG_IDX_W = $clog2(HD_MAX);
    localparam int ND_W      = $clog2(HD_MAX + 1);
    localparam longint unsigned SAT_LIMIT = pow10(MAX_HOUR_DIGITS) * 3600 - 1;

    localparam logic [POS_W-1:0] REL_COLON_H = 4'd0;
    localparam logic [POS_W-1:0] REL_MIN_T   = 4'd1;
    localparam logic [POS_W-1:0] REL_MIN_O   = 4'd2;
    localparam logic [POS_W-1:0] REL_COLON_M = 4'd3;
    localparam logic [POS_W-1:0] REL_SEC_T   = 4'd4;
    localparam logic [POS_W-1:0] REL_SEC_O   = 4'd5;

    logic [IN_W-1:0]    r_secs;
    logic [Q1_W-1:0]    r_q1;
    logic [HOURS_W-1:0] r_hours;
    logic [HOURS_W-1:0] r_hval;
    logic [5:0]         r_mins;
    logic [5:0]         r_ss;
    logic [3:0]         r_digits [HD_MAX];
    logic [ND_W-1:0]    r_nd;
    logic [POS_W-1:0]   r_pos;

    logic [52:0]        w_prod_a;
    logic [42:0]        w_prod_b;
    logic [30:0]        w_prod_d;
    logic [HOURS_W-1:0] w_q10;
    logic               w_sat;
    logic [ND_W-1:0]    w_hd;
    logic [POS_W-1:0]   w_hd_pos;
    logic [POS_W-1:0]   w_rel;
    logic [POS_W-1:0]   w_off;
    logic [3:0]         w_min_t;
    logic [3:0]         w_sec_t;
    logic [SYM_W-1:0]   w_sym;

    assign w_prod_a = 53'(r_secs) * 53'(M60_A);
    assign w_prod_b = 43'(r_q1) * 43'(M60_B);
    assign w_prod_d = 31'(r_hval) * 31'(M10);
    assign w_q10    = HOURS_W'(w_prod_d[30:M10_SH]);
    assign w_sat    = 64'(r_secs) > 64'(SAT_LIMIT);

    // Hours are padded to an even digit count.
    assign w_hd     = r_nd + ND_W'(r_nd[0]);
    assign w_hd_pos = POS_W'(w_hd);
    assign w_rel    = r_pos - w_hd_pos;
    assign w_off    = w_hd_pos - 4'd1 - r_pos;
    assign w_min_t  = tens_of(r_mins);
    assign w_sec_t  = tens_of(r_ss);

    always_comb begin
        if (r_pos < w_hd_pos) begin
            w_sym = r_digits[w_off[DIG_IDX_W-1:0]];
        end else begin
            case (w_rel)
                REL_COLON_H: w_sym = SYM_COLON;
                REL_MIN_T:   w_sym = w_min_t;
                REL_MIN_O:   w_sym = r_mins[3:0] - 4'(w_min_t * 4'd10);
                REL_COLON_M: w_sym = SYM_COLON;
                REL_SEC_T:   w_sym = w_sec_t;
                default:     w_sym = r_ss[3:0] - 4'(w_sec_t * 4'd10);
            endcase
        end
    end

    assign o_stat.sat        = w_sat;
    assign o_stat.hval_small = r_hval < HOURS_W'(10);
    assign o_stat.last_pos   = (r_pos >= w_hd_pos) && (w_rel == REL_SEC_O);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_secs <= i_total_seconds;
        end
        if (i_cmd.div_a) begin
            r_q1 <= w_prod_a[M60_A_SH +: Q1_W];
        end
        if (i_cmd.div_b) begin
            r_hours <= w_prod_b[M60_B_SH +: HOURS_W];
            r_ss    <= r_secs[5:0] - 6'(r_q1[5:0] * 6'd60);
        end
        if (i_cmd.setup) begin
            r_pos  <= '0;
            r_hval <= r_hours;
            if (w_sat) begin
                r_mins <= 6'd59;
                r_ss   <= 6'd59;
                r_nd   <= ND_W'(MAX_HOUR_DIGITS);
                for (int i = 0; i < HD_MAX; i++) begin
                    r_digits[i] <= (i < MAX_HOUR_DIGITS) ? SYM_NINE : 4'd0;
                end
            end else begin
                r_mins <= r_q1[5:0] - 6'(r_hours[5:0] * 6'd60);
                r_nd   <= '0;
                for (int i = 0; i < HD_MAX; i++) begin
                    r_digits[i] <= 4'd0;
                end
            end
        end
        if (i_cmd.digit_step) begin
            // Peel off the lowest decimal digit.
            r_digits[r_nd[DIG_IDX_W-1:0]] <= r_hval[3:0] - 4'(w_q10[3:0] * 4'd10);
            r_hval <= w_q10;
            r_nd   <= r_nd + 1'b1;
        end
        if (i_cmd.emit) begin
            o_char_position <= r_pos;
            o_symbol_code   <= w_sym;
            o_glyph_bits    <= glyph_of(w_sym);
            o_last_char     <= o_stat.last_pos;
            r_pos           <= r_pos + 1'b1;
        end
    end

endmodule

// ===== rtl/s2cg_ctrl.sv =====
// Controller: sequences the conversion steps and the character transfers.
`timescale 1ns / 1ps

module s2cg_ctrl import s2cg_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_DIV_A, S_DIV_B, S_SETUP, S_DIGIT, S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   n_out_valid;
    logic   w_slot_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_slot_free = !o_out_valid || i_out_ready;

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_out_valid = o_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV_A;
                end
            end
            S_DIV_A: begin
                o_cmd.div_a = 1'b1;
                n_state     = S_DIV_B;
            end
            S_DIV_B: begin
                o_cmd.div_b = 1'b1;
                n_state     = S_SETUP;
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = i_stat.sat ? S_EMIT : S_DIGIT;
            end
            S_DIGIT: begin
                o_cmd.digit_step = 1'b1;
                if (i_stat.hval_small) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // Load the next character once the output register drains.
                if (w_slot_free) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    if (i_stat.last_pos) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            o_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/seconds_to_clock_glyphs.sv =====
// The input transfer loads the seconds; divide-by-60 steps, a setup step and one digit
// step per hour digit (1 to 4, unless saturated) follow, then one character per cycle
// while the sink is ready, (even-padded hour digits + 6) characters in all. The digit
// steps share one multiplier; a new time value is taken only once the last character is
// in the single output register. Reset (synchronous, active low) clears the controller
// state and the output valid; payload registers are not reset.
`timescale 1ns / 1ps

module seconds_to_clock_glyphs import s2cg_pkg::*; #(
    parameter int MAX_HOUR_DIGITS = DEF_MAX_HOUR_DIGITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    s2cg_in_if.sink    i_in,
    s2cg_out_if.source o_out
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    s2cg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    s2cg_dp #(
        .MAX_HOUR_DIGITS (MAX_HOUR_DIGITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_cmd           (w_cmd),
        .i_total_seconds (i_in.total_seconds),
        .o_stat          (w_stat),
        .o_char_position (o_out.char_position),
        .o_symbol_code   (o_out.symbol_code),
        .o_glyph_bits    (o_out.glyph_bits),
        .o_last_char     (o_out.last_char)
    );

endmodule

// ===== rtl/s2cg_chk.sv =====
// Port-level checker for the glyph block and its bind to the top level.
`timescale 1ns / 1ps

module s2cg_chk import s2cg_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [POS_W-1:0]   i_char_position,
    input logic [SYM_W-1:0]   i_symbol_code,
    input logic [GLYPH_W-1:0] i_glyph_bits,
    input logic               i_last_char
);

    // Hold a stalled character.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_glyph_bits)
            && $stable(i_char_position))
        else $error("stalled output changed");

    // Advance without gaps inside one run.
    a_run_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_last_char |=> i_out_valid
            && (i_char_position == $past(i_char_position) + 4'd1))
        else $error("run did not continue with the next position");

    // A run holds at least two hour digits and six more characters.
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_last_char |-> i_char_position >= 4'd7)
        else $error("run ended too early");

    a_colon_glyph: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_symbol_code == SYM_COLON) |-> i_glyph_bits == glyph_of(SYM_COLON))
        else $error("colon glyph mismatch");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second time value taken during conversion");

endmodule

bind seconds_to_clock_glyphs s2cg_chk u_s2cg_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_char_position (o_out.char_position),
    .i_symbol_code   (o_out.symbol_code),
    .i_glyph_bits    (o_out.glyph_bits),
    .i_last_char     (o_out.last_char)
);

// ===== bench/s2cg_checker.sv =====
// Checker that predicts each time value's glyph run and compares it with every glyph transfer.
`timescale 1ns / 1ps

module s2cg_checker import s2cg_pkg::*; #(
    parameter int MAX_HOUR_DIGITS = DEF_MAX_HOUR_DIGITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    s2cg_in_if   i_time_ch,
    s2cg_out_if  i_glyph_ch,
    output int   o_pending,
    output int   o_fail_count,
    output int   o_times_seen,
    output int   o_glyphs_checked,
    output int   o_saturated,
    output int   o_wide_hours
);

    typedef struct packed {
        logic [POS_W-1:0]   pos;
        logic [SYM_W-1:0]   sym;
        logic [GLYPH_W-1:0] glyph;
        logic               last;
    } t_clock_char;

    t_clock_char        char_queue[$];
    t_clock_char        want;
    logic [GLYPH_W-1:0] font_rom [0:10];

    initial begin
        font_rom[0]  = {R_FULL, R_SIDES, R_SIDES, R_SIDES, R_SIDES, R_SIDES, R_FULL};
        font_rom[1]  = {R_RIGHT, R_RIGHT, R_RIGHT, R_RIGHT, R_RIGHT, R_RIGHT, R_RIGHT};
        font_rom[2]  = {R_FULL, R_RIGHT, R_RIGHT, R_FULL, R_LEFT, R_LEFT, R_FULL};
        font_rom[3]  = {R_FULL, R_RIGHT, R_RIGHT, R_FULL, R_RIGHT, R_RIGHT, R_FULL};
        font_rom[4]  = {R_SIDES, R_SIDES, R_SIDES, R_FULL, R_RIGHT, R_RIGHT, R_RIGHT};
        font_rom[5]  = {R_FULL, R_LEFT, R_LEFT, R_FULL, R_RIGHT, R_RIGHT, R_FULL};
        font_rom[6]  = {R_FULL, R_LEFT, R_LEFT, R_FULL, R_SIDES, R_SIDES, R_FULL};
        font_rom[7]  = {R_FULL, R_RIGHT, R_RIGHT, R_RIGHT, R_RIGHT, R_RIGHT, R_RIGHT};
        font_rom[8]  = {R_FULL, R_SIDES, R_SIDES, R_FULL, R_SIDES, R_SIDES, R_FULL};
        font_rom[9]  = {R_FULL, R_SIDES, R_SIDES, R_FULL, R_RIGHT, R_RIGHT, R_FULL};
        font_rom[10] = {R_NONE, R_BAR, R_BAR, R_NONE, R_BAR, R_BAR, R_NONE};
        o_pending        = 0;
        o_fail_count     = 0;
        o_times_seen     = 0;
        o_glyphs_checked = 0;
        o_saturated      = 0;
        o_wide_hours     = 0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        $display("%0t ns glyph check failed, %s: got %0h, want %0h", $time, what, got, exp_val);
        o_fail_count++;
    endtask

    // Split the seconds, pad the hours to an even digit count, queue one char per symbol.
    task automatic queue_clock_text(input logic [IN_W-1:0] secs);
        longint unsigned  s;
        longint unsigned  hrs;
        longint unsigned  mins;
        longint unsigned  sec_part;
        longint unsigned  cap;
        longint unsigned  v;
        int               ndig;
        int               hdig;
        logic [SYM_W-1:0] text[$];
        t_clock_char      c;
        s   = 64'(secs);
        cap = 1;
        for (int k = 0; k < MAX_HOUR_DIGITS; k++) begin
            cap = cap * 10;
        end
        cap = cap - 1;
        if (s > cap * 3600 + 3599) begin
            hrs      = cap;
            mins     = 59;
            sec_part = 59;
            o_saturated++;
        end else begin
            hrs      = s / 3600;
            mins     = (s / 60) % 60;
            sec_part = s % 60;
        end
        ndig = 1;
        v    = hrs;
        while (v >= 10) begin
            v = v / 10;
            ndig++;
        end
        hdig = ((ndig + 1) / 2) * 2;
        if (hdig > 2) begin
            o_wide_hours++;
        end
        v = hrs;
        for (int k = 0; k < hdig; k++) begin
            text.push_front(SYM_W'(v % 10));
            v = v / 10;
        end
        text.push_back(SYM_COLON);
        text.push_back(SYM_W'(mins / 10));
        text.push_back(SYM_W'(mins % 10));
        text.push_back(SYM_COLON);
        text.push_back(SYM_W'(sec_part / 10));
        text.push_back(SYM_W'(sec_part % 10));
        for (int k = 0; k < text.size(); k++) begin
            c.pos   = POS_W'(k);
            c.sym   = text[k];
            c.glyph = font_rom[text[k]];
            c.last  = (k == text.size() - 1);
            char_queue.push_back(c);
        end
        o_times_seen++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_time_ch.valid && i_time_ch.ready) begin
                queue_clock_text(i_time_ch.total_seconds);
            end
            if (i_glyph_ch.valid && i_glyph_ch.ready) begin
                if (char_queue.size() == 0) begin
                    report_mismatch("glyph with nothing pending",
                                    64'(i_glyph_ch.char_position), 64'd0);
                end else begin
                    want = char_queue.pop_front();
                    o_glyphs_checked++;
                    if (i_glyph_ch.char_position !== want.pos) begin
                        report_mismatch("char_position", 64'(i_glyph_ch.char_position),
                                        64'(want.pos));
                    end
                    if (i_glyph_ch.symbol_code !== want.sym) begin
                        report_mismatch("symbol_code", 64'(i_glyph_ch.symbol_code),
                                        64'(want.sym));
                    end
                    if (i_glyph_ch.glyph_bits !== want.glyph) begin
                        report_mismatch("glyph_bits", 64'(i_glyph_ch.glyph_bits),
                                        64'(want.glyph));
                    end
                    if (i_glyph_ch.last_char !== want.last) begin
                        report_mismatch("last_char", 64'(i_glyph_ch.last_char),
                                        64'(want.last));
                    end
                end
            end
            o_pending <= char_queue.size();
        end
    end

endmodule

// ===== bench/tb_top.sv =====
// Testbench top: drives time values and glyph back-pressure, and gives the verdict.
`timescale 1ns / 1ps

module tb_top;
    import s2cg_pkg::*;

    localparam int HOUR_DIGITS  = DEF_MAX_HOUR_DIGITS;
    localparam int RANDOM_TIMES = 160;
    localparam int STALL_LIMIT  = 500;
    localparam int TAIL_CYCLES  = 40;
    // Largest value shown without saturation for four hour digits: 9999:59:59.
    localparam logic [IN_W-1:0] LAST_PLAIN = 26'd35999999;

    logic i_clk;
    logic i_rst_n;
    logic calm;
    int   stall_cycles;
    int   pending;
    int   fail_count;
    int   times_seen;
    int   glyphs_checked;
    int   saturated;
    int   wide_hours;

    s2cg_in_if  time_ch ();
    s2cg_out_if glyph_ch ();

    seconds_to_clock_glyphs #(.MAX_HOUR_DIGITS(HOUR_DIGITS)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (time_ch),
        .o_out   (glyph_ch)
    );

    s2cg_checker #(.MAX_HOUR_DIGITS(HOUR_DIGITS)) i_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_time_ch        (time_ch),
        .i_glyph_ch       (glyph_ch),
        .o_pending        (pending),
        .o_fail_count     (fail_count),
        .o_times_seen     (times_seen),
        .o_glyphs_checked (glyphs_checked),
        .o_saturated      (saturated),
        .o_wide_hours     (wide_hours)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        glyph_ch.ready <= calm || ($urandom_range(99) >= 16);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (time_ch.valid && time_ch.ready) ||
            (glyph_ch.valid && glyph_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d glyphs pending",
                     stall_cycles, pending);
            $display("end of test: mismatches");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_time(input logic [IN_W-1:0] secs);
        while (!calm && $urandom_range(99) < 16) begin
            time_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        time_ch.valid         <= 1'b1;
        time_ch.total_seconds <= secs;
        do @(posedge i_clk); while (!time_ch.ready);
    endtask

    // Hold the sender off until every queued glyph has come out.
    task automatic wait_drained();
        time_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        int               pick;
        logic [IN_W-1:0]  secs;
        i_rst_n               = 1'b0;
        calm                  = 1'b0;
        stall_cycles          = 0;
        time_ch.valid         = 1'b0;
        time_ch.total_seconds = '0;
        glyph_ch.ready        = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Field extremes, digit-count boundaries and the saturation edge.
        send_time(26'd0);
        send_time(26'd1);
        send_time(26'd59);
        send_time(26'd60);
        send_time(26'd3599);
        send_time(26'd3600);
        send_time(26'd35999);
        send_time(26'd36000);
        send_time(26'd359999);
        send_time(26'd360000);
        send_time(26'd4445767);
        send_time(26'd20441388);
        send_time(LAST_PLAIN - 26'd1);
        send_time(LAST_PLAIN);
        send_time(LAST_PLAIN + 26'd1);
        send_time(26'h2AAAAAA);
        send_time(26'h1555555);
        send_time(26'h3FFFFFF);
        wait_drained();

        for (int n = 0; n < RANDOM_TIMES; n++) begin
            calm <= (n >= 70 && n < 110);
            pick = $urandom_range(99);
            if (pick < 35) begin
                secs = IN_W'($urandom_range(35999));
            end else if (pick < 60) begin
                secs = IN_W'($urandom_range(359999, 36000));
            end else if (pick < 85) begin
                secs = IN_W'($urandom_range(LAST_PLAIN, 360000));
            end else if (pick < 93) begin
                secs = IN_W'($urandom_range(LAST_PLAIN + 12, LAST_PLAIN - 12));
            end else begin
                secs = IN_W'($urandom());
            end
            send_time(secs);
            if (n == 120) begin
                wait_drained();
            end
        end
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d time values: %0d saturated, %0d with four-digit hours",
                 times_seen, saturated, wide_hours);
        $display("compared %0d glyph transfers under random stalls on both sides",
                 glyphs_checked);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
